FILE: rtl/core/rtcp_report_interval_defines.svh
// Assertion macros for the RTCP report interval core.
// Included by RTL files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef RTCP_REPORT_INTERVAL_DEFINES_SVH
`define RTCP_REPORT_INTERVAL_DEFINES_SVH

`ifndef SYNTHESIS
`define RTCP_RI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rtcp_report_interval: assertion failed");
`define RTCP_RI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rtcp_report_interval: assertion failed");
`else
`define RTCP_RI_ASSERT_IMP(lbl, ante, cons)
`define RTCP_RI_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/rtcp_ri_pkg.sv
// Shared widths, fixed-point constants and types for the RTCP report interval core.
// No dependencies; used by rtcp_ri_div and rtcp_report_interval.
package rtcp_ri_pkg;

  localparam int unsigned NUM_W = 49;
  localparam int unsigned DEN_W = 34;
  localparam int unsigned QUO_W = 48;
  localparam int unsigned RND_W = 30;

  localparam logic [14:0] BW_MS_K      = 15'd20000;
  localparam logic [47:0] MIN_Q16      = 48'd327680000;
  localparam logic [47:0] MIN_INIT_Q16 = 48'd163840000;
  localparam logic [30:0] HALF_Q30     = 31'h2000_0000;
  localparam logic [15:0] INV_COMP_Q16 = 16'd53794;

  typedef struct packed {
    logic             init_call;
    logic [RND_W-1:0] rnd;
  } side_t;

endpackage

FILE: rtl/core/rtcp_report_interval.sv
// RTCP report interval: one request per beat, one interval per request.
// Path: a request passes s0 to s2, the divider, p1 to p4 and then the output register.
// Throughput: one request per cycle while in_stall_o is low; the 48-stage bit-per-stage divider sets the depth.
// Reset clears all valid bits, those of the output and skid registers included.
// Depends on rtcp_ri_pkg, rtcp_ri_div and rtcp_report_interval_defines.svh.
`include "rtcp_report_interval_defines.svh"

module rtcp_report_interval (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        did_send_i,
  input  logic        initial_call_i,
  input  logic [31:0] bandwidth_bps_i,
  input  logic [15:0] member_count_i,
  input  logic [15:0] sender_count_i,
  input  logic [15:0] avg_packet_octets_i,
  input  logic [29:0] random_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] interval_ms_o
);

  localparam int unsigned NW = rtcp_ri_pkg::NUM_W;
  localparam int unsigned DW = rtcp_ri_pkg::DEN_W;
  localparam int unsigned QW = rtcp_ri_pkg::QUO_W;

  logic pipe_en;

  logic               quarter;
  logic [32:0]        bw1;
  logic [15:0]        n_c;
  logic [DW-1:0]      den_c;
  rtcp_ri_pkg::side_t side_c;

  logic               s0_v_q;
  logic [15:0]        s0_avg_q;
  logic [15:0]        s0_n_q;
  logic               s0_quarter_q;
  logic [DW-1:0]      s0_den_q;
  rtcp_ri_pkg::side_t s0_side_q;

  logic               s1_v_q;
  logic [31:0]        s1_prod_q;
  logic               s1_quarter_q;
  logic [DW-1:0]      s1_den_q;
  rtcp_ri_pkg::side_t s1_side_q;

  logic [46:0]        prod_k;
  logic               s2_v_q;
  logic [NW-1:0]      s2_num_q;
  logic [DW-1:0]      s2_den_q;
  rtcp_ri_pkg::side_t s2_side_q;

  logic               dv_valid;
  logic [QW-1:0]      dv_quot;
  logic               dv_sat;
  rtcp_ri_pkg::side_t dv_side;

  logic [QW-1:0]      t_c;
  logic [QW-1:0]      tmin;
  logic               p1_v_q;
  logic [QW-1:0]      p1_t_q;
  logic [30:0]        p1_m_q;

  logic               p2_v_q;
  logic [54:0]        p2_a_q;
  logic [54:0]        p2_b_q;

  logic [55:0]        lo_ab;
  logic               p3_v_q;
  logic [48:0]        p3_d_q;

  logic               p4_v_q;
  logic [48:0]        p4_x_q;
  logic [31:0]        p4_y_q;

  logic [32:0]        lo_xy;
  logic [33:0]        res;
  logic [31:0]        res_sat;

  logic               out_v_q;
  logic [31:0]        out_ms_q;
  logic               skid_v_q;
  logic [31:0]        skid_ms_q;
  logic               out_free;
  logic               arrive;

  assign pipe_en    = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_comb begin
    quarter = (sender_count_i != 16'd0) &&
              ({sender_count_i, 2'b00} < {2'b00, member_count_i});
    bw1     = {1'b0, bandwidth_bps_i} + 33'd1;
    n_c     = member_count_i;
    den_c   = {1'b0, bw1};
    if (quarter) begin
      if (did_send_i) begin
        n_c = sender_count_i;
      end else begin
        n_c   = member_count_i - sender_count_i;
        den_c = {bw1, 1'b0} + {1'b0, bw1};
      end
    end
    side_c.init_call = initial_call_i;
    side_c.rnd       = random_word_i;
  end

  assign prod_k = 47'(s1_prod_q) * 47'(rtcp_ri_pkg::BW_MS_K);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
    end else if (pipe_en) begin
      s0_v_q <= in_valid_i;
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
      p1_v_q <= dv_valid;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s0_avg_q     <= avg_packet_octets_i;
      s0_n_q       <= n_c;
      s0_quarter_q <= quarter;
      s0_den_q     <= den_c;
      s0_side_q    <= side_c;

      s1_prod_q    <= 32'(s0_avg_q) * 32'(s0_n_q);
      s1_quarter_q <= s0_quarter_q;
      s1_den_q     <= s0_den_q;
      s1_side_q    <= s0_side_q;

      s2_num_q     <= s1_quarter_q ? {prod_k, 2'b00} : {2'b00, prod_k};
      s2_den_q     <= s1_den_q;
      s2_side_q    <= s1_side_q;

      p1_t_q       <= t_c;
      p1_m_q       <= 31'(dv_side.rnd) + rtcp_ri_pkg::HALF_Q30;

      p2_a_q       <= 55'(p1_t_q[47:24]) * 55'(p1_m_q);
      p2_b_q       <= 55'(p1_t_q[23:0]) * 55'(p1_m_q);

      p3_d_q       <= p2_a_q[54:6] + 49'(lo_ab[55:30]);

      p4_x_q       <= 49'(p3_d_q[48:16]) * 49'(rtcp_ri_pkg::INV_COMP_Q16);
      p4_y_q       <= 32'(p3_d_q[15:0]) * 32'(rtcp_ri_pkg::INV_COMP_Q16);
    end
  end

  rtcp_ri_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s2_v_q),
    .num_i   (s2_num_q),
    .den_i   (s2_den_q),
    .side_i  (s2_side_q),
    .valid_o (dv_valid),
    .quot_o  (dv_quot),
    .sat_o   (dv_sat),
    .side_o  (dv_side)
  );

  always_comb begin
    tmin = dv_side.init_call ? rtcp_ri_pkg::MIN_INIT_Q16 : rtcp_ri_pkg::MIN_Q16;
    t_c  = dv_sat ? {QW{1'b1}} : dv_quot;
    if (t_c < tmin) begin
      t_c = tmin;
    end
  end

  assign lo_ab   = {26'd0, p2_a_q[5:0], 24'd0} + {1'b0, p2_b_q};
  assign lo_xy   = {1'b0, p4_x_q[15:0], 16'd0} + {1'b0, p4_y_q};
  assign res     = {1'b0, p4_x_q[48:16]} + 34'(lo_xy[32]);
  assign res_sat = (res[33:32] != 2'b00) ? 32'hFFFF_FFFF : res[31:0];

  assign out_free = !out_v_q || !out_stall_i;
  assign arrive   = pipe_en && p4_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_v_q  <= skid_v_q || arrive;
        skid_v_q <= 1'b0;
      end else if (arrive) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_ms_q <= skid_v_q ? skid_ms_q : res_sat;
    end else if (arrive) begin
      skid_ms_q <= res_sat;
    end
  end

  assign out_valid_o   = out_v_q;
  assign interval_ms_o = out_ms_q;

  `RTCP_RI_ASSERT_IMP(a_skid_needs_out, skid_v_q, out_v_q)
  `RTCP_RI_ASSERT_NXT(a_skid_holds, skid_v_q && out_stall_i, skid_v_q && $stable(skid_ms_q))
  `RTCP_RI_ASSERT_NXT(a_skid_drains, skid_v_q && !out_stall_i, !skid_v_q && out_v_q)
  `RTCP_RI_ASSERT_NXT(a_pipe_frozen, skid_v_q, $stable(p4_v_q) && $stable(p4_x_q))

endmodule

FILE: rtl/core/rtcp_ri_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detection.
// Depends on rtcp_ri_pkg for widths and the side payload type.
module rtcp_ri_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [rtcp_ri_pkg::NUM_W-1:0]   num_i,
  input  logic [rtcp_ri_pkg::DEN_W-1:0]   den_i,
  input  rtcp_ri_pkg::side_t              side_i,
  output logic                            valid_o,
  output logic [rtcp_ri_pkg::QUO_W-1:0]   quot_o,
  output logic                            sat_o,
  output rtcp_ri_pkg::side_t              side_o
);

  localparam int unsigned QW = rtcp_ri_pkg::QUO_W;
  localparam int unsigned DW = rtcp_ri_pkg::DEN_W;
  localparam int unsigned NW = rtcp_ri_pkg::NUM_W;
  localparam int unsigned HW = NW - 32;

  logic                      v_q    [0:QW];
  logic [DW-1:0]             r_q    [0:QW];
  logic [QW-1:0]             w_q    [0:QW];
  logic [DW-1:0]             den_q  [0:QW];
  logic                      sat_q  [0:QW];
  rtcp_ri_pkg::side_t        side_q [0:QW];

  logic [DW-1:0]             r_d    [0:QW-1];
  logic [QW-1:0]             w_d    [0:QW-1];

  logic [DW-1:0]             num_hi;

  assign num_hi = {{(DW-HW){1'b0}}, num_i[NW-1:32]};

  always_comb begin
    logic [DW:0] rs;
    logic [DW:0] diff;
    logic        qb;
    for (int k = 0; k < QW; k++) begin
      rs     = {r_q[k], w_q[k][QW-1]};
      diff   = rs - {1'b0, den_q[k]};
      qb     = (rs >= {1'b0, den_q[k]});
      r_d[k] = qb ? diff[DW-1:0] : rs[DW-1:0];
      w_d[k] = {w_q[k][QW-2:0], qb};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QW; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 0; k < QW; k++) begin
        v_q[k+1] <= v_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= num_hi;
      w_q[0]    <= {num_i[31:0], {(QW-32){1'b0}}};
      den_q[0]  <= den_i;
      sat_q[0]  <= (num_hi >= den_i);
      side_q[0] <= side_i;
      for (int k = 0; k < QW; k++) begin
        r_q[k+1]    <= r_d[k];
        w_q[k+1]    <= w_d[k];
        den_q[k+1]  <= den_q[k];
        sat_q[k+1]  <= sat_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = v_q[QW];
  assign quot_o  = w_q[QW];
  assign sat_o   = sat_q[QW];
  assign side_o  = side_q[QW];

endmodule
